// File: hdl/yenc_line_encoder_crc32_assert.svh
// Assertion macros shared by the encoder modules.
`ifndef YENC_LINE_ENCODER_CRC32_ASSERT_SVH
`define YENC_LINE_ENCODER_CRC32_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define YLE_ASSERT_ALWAYS(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("yle assertion failed");

// Condition that must hold whenever the antecedent holds.
`define YLE_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("yle assertion failed");

`endif

// File: hdl/yle_pkg.sv
package yle_pkg;

	localparam logic [7:0]  ENC_OFFSET   = 8'd42;
	localparam logic [7:0]  ESC_OFFSET   = 8'd64;
	localparam logic [7:0]  ESC_CHAR     = 8'h3D;
	localparam logic [7:0]  DOT_CHAR     = 8'h2E;
	localparam logic [7:0]  NUL_CHAR     = 8'h00;
	localparam logic [7:0]  TAB_CHAR     = 8'h09;
	localparam logic [7:0]  CR_CHAR      = 8'h0D;
	localparam logic [7:0]  LF_CHAR      = 8'h0A;
	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
	localparam logic [7:0]  LINE_LEN_RST = 8'd128;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// One classified input byte: everything the back end needs to emit its words.
	typedef struct packed {
		logic [7:0]  enc;
		logic        esc;
		logic        crlf;
		logic [31:0] crc;
		logic        last;
	} run_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == NUL_CHAR) || (b == TAB_CHAR) || (b == LF_CHAR) || (b == CR_CHAR)
			|| (b == ESC_CHAR) || (b == DOT_CHAR);
	endfunction

endpackage

// File: hdl/yenc_line_encoder_crc32.sv
// A pushed byte goes into the queue, then its first word is loaded into the output register.
// Throughput: a byte a cycle while not full; one to four words per byte, one a cycle while popped.
// The four-entry queue between the classifier and the word emitter sets how long pushes outrun pops.
// Reset (arst_n low, asynchronous): CRC all ones, line count zero, line length 128, all queues empty.
module yenc_line_encoder_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        end_of_run,
	output logic [31:0] crc_value,
	output logic        part_end
);

	// The front end classifies each byte in the cycle it is pushed: it folds the byte
	// into the running CRC, applies the offset, decides on the escape and on the line
	// end, and keeps the line count. The whole run is described by one queue record.
	yle_pkg::run_t rec;
	yle_pkg::run_t head;
	logic          accept;
	logic          fifo_rd;
	logic          fifo_empty;

	// A byte is taken whenever the queue has room; the back end never stalls the front
	// directly, only through the queue filling up.
	assign accept = push && !full;

	yle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec       (rec)
	);

	// The queue decouples the one-record-per-byte front from the one-word-per-cycle
	// back end, so short bursts of escapes and line ends do not stall the input.
	yle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (accept),
		.wdata      (rec),
		.rd         (fifo_rd),
		.rdata      (head),
		.full       (full),
		.fifo_empty (fifo_empty)
	);

	// The back end walks through the words of the head record into an output
	// register; it loads a new word in the same cycle that the waiting one is popped,
	// and frees the queue entry as it loads the last word of the run.
	yle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_empty (fifo_empty),
		.fifo_rd    (fifo_rd),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.end_of_run (end_of_run),
		.crc_value  (crc_value),
		.part_end   (part_end)
	);

endmodule

// File: hdl/yle_front.sv
`include "yenc_line_encoder_crc32_assert.svh"

module yle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output yle_pkg::run_t       rec
);

	logic [7:0]  line_length_q;
	logic [31:0] crc_q;
	logic [8:0]  line_fill_q;

	logic [7:0]  enc_raw;
	logic        esc;
	logic [8:0]  fill_next;
	logic        crlf;
	logic [31:0] crc_new;

	always_comb begin
		enc_raw   = data_byte + yle_pkg::ENC_OFFSET;
		esc       = yle_pkg::needs_escape(enc_raw);
		fill_next = line_fill_q + (esc ? 9'd2 : 9'd1);
		crlf      = last_byte || (fill_next >= {1'b0, line_length_q});
		crc_new   = yle_pkg::crc_byte(crc_q, data_byte);
		rec.enc   = esc ? (enc_raw + yle_pkg::ESC_OFFSET) : enc_raw;
		rec.esc   = esc;
		rec.crlf  = crlf;
		rec.crc   = ~crc_new;
		rec.last  = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= yle_pkg::LINE_LEN_RST;
		end else if (cfg_we) begin
			line_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= yle_pkg::CRC_INIT;
			line_fill_q <= 9'd0;
		end else if (accept) begin
			crc_q       <= last_byte ? yle_pkg::CRC_INIT : crc_new;
			line_fill_q <= crlf ? 9'd0 : fill_next;
		end
	end

	// A line that is not closed is always shorter than the longest line length.
	`YLE_ASSERT_ALWAYS(a_fill_range, clk, arst_n, line_fill_q < 9'd255)

endmodule

// File: hdl/yle_fifo.sv
`include "yenc_line_encoder_crc32_assert.svh"

module yle_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  yle_pkg::run_t       wdata,
	input  logic                rd,
	output yle_pkg::run_t       rdata,
	output logic                full,
	output logic                fifo_empty
);

	yle_pkg::run_t                     mem_q [yle_pkg::FIFO_DEPTH];
	logic [yle_pkg::PTR_W-1:0]         wptr_q;
	logic [yle_pkg::PTR_W-1:0]         rptr_q;
	logic [yle_pkg::CNT_W-1:0]         cnt_q;

	assign full       = (cnt_q == yle_pkg::CNT_W'(yle_pkg::FIFO_DEPTH));
	assign fifo_empty = (cnt_q == '0);
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`YLE_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= yle_pkg::CNT_W'(yle_pkg::FIFO_DEPTH))

endmodule

// File: hdl/yle_back.sv
`include "yenc_line_encoder_crc32_assert.svh"

module yle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  yle_pkg::run_t       head,
	input  logic                fifo_empty,
	output logic                fifo_rd,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          out_byte,
	output logic                end_of_run,
	output logic [31:0]         crc_value,
	output logic                part_end
);

	logic [1:0]  idx_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        oend_q;
	logic [31:0] ocrc_q;
	logic        opart_q;

	logic        load;
	logic        at_end;
	logic [7:0]  sel_byte;

	// Words of a run: optional escape, data, then optional CR LF.
	always_comb begin
		load   = (!ovalid_q || pop) && !fifo_empty;
		at_end = (idx_q == {head.crlf, head.esc});
		unique case (idx_q)
			2'd0:    sel_byte = head.esc ? yle_pkg::ESC_CHAR : head.enc;
			2'd1:    sel_byte = head.esc ? head.enc : yle_pkg::CR_CHAR;
			2'd2:    sel_byte = head.esc ? yle_pkg::CR_CHAR : yle_pkg::LF_CHAR;
			default: sel_byte = yle_pkg::LF_CHAR;
		endcase
		fifo_rd = load && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q    <= at_end ? 2'd0 : (idx_q + 2'd1);
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= sel_byte;
			oend_q  <= at_end;
			ocrc_q  <= head.crc;
			opart_q <= head.last;
		end
	end

	assign empty      = !ovalid_q;
	assign out_byte   = obyte_q;
	assign end_of_run = oend_q;
	assign crc_value  = ocrc_q;
	assign part_end   = opart_q;

	// A run in progress keeps its record at the head of the queue.
	`YLE_ASSERT_IMPLY(a_run_held, clk, arst_n, idx_q != 2'd0, !fifo_empty)
	// A fourth word exists only for an escaped byte that closes a line.
	`YLE_ASSERT_IMPLY(a_four_words, clk, arst_n, load && (idx_q == 2'd3), head.esc && head.crlf)

endmodule

// File: bench/yenc_checker.sv
`timescale 1ns / 1ps

module yenc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_byte,
	input  logic        end_of_run,
	input  logic [31:0] crc_value,
	input  logic        part_end,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0]  code;
		logic        run_end;
		logic [31:0] crc;
		logic        part_end;
	} enc_word_t;

	enc_word_t   words_due[$];
	logic [31:0] crc_acc;
	logic [8:0]  fill;
	logic [7:0]  line_len;

	// Appends the words that one source byte turns into and advances the line and CRC state.
	task automatic encode_byte(input logic [7:0] d, input logic l);
		logic [31:0] c;
		logic [7:0]  enc;
		logic [7:0]  codes [4];
		int          n;
		enc_word_t   w;
		c = crc_acc ^ {24'd0, d};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ yle_pkg::CRC_POLY) : (c >> 1);
		end
		crc_acc = c;
		enc = d + yle_pkg::ENC_OFFSET;
		n = 0;
		if (enc inside {yle_pkg::NUL_CHAR, yle_pkg::TAB_CHAR, yle_pkg::LF_CHAR,
				yle_pkg::CR_CHAR, yle_pkg::ESC_CHAR, yle_pkg::DOT_CHAR}) begin
			codes[n] = yle_pkg::ESC_CHAR;
			n = n + 1;
			fill = fill + 9'd1;
			enc = enc + yle_pkg::ESC_OFFSET;
		end
		codes[n] = enc;
		n = n + 1;
		fill = fill + 9'd1;
		if (fill >= {1'b0, line_len} || l) begin
			codes[n] = yle_pkg::CR_CHAR;
			codes[n + 1] = yle_pkg::LF_CHAR;
			n = n + 2;
			fill = '0;
		end
		for (int k = 0; k < n; k++) begin
			w.code = codes[k];
			w.run_end = (k == n - 1);
			w.crc = c ^ yle_pkg::CRC_INIT;
			w.part_end = l;
			words_due.push_back(w);
		end
		if (l) begin
			crc_acc = yle_pkg::CRC_INIT;
			fill = '0;
		end
	endtask

	function automatic int report(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int        fails;
		enc_word_t w;
		if (!arst_n) begin
			crc_acc = yle_pkg::CRC_INIT;
			fill = '0;
			line_len = yle_pkg::LINE_LEN_RST;
			words_due.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			fails = 0;
			if (pop && !empty) begin
				if (words_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, out_byte);
					fails = fails + 1;
				end else begin
					w = words_due.pop_front();
					fails = fails + report("out_byte", 32'(w.code), 32'(out_byte));
					fails = fails + report("end_of_run", 32'(w.run_end), 32'(end_of_run));
					fails = fails + report("crc_value", w.crc, crc_value);
					fails = fails + report("part_end", 32'(w.part_end), 32'(part_end));
				end
			end
			if (cfg_we)
				line_len = cfg_wdata;
			if (push && !full)
				encode_byte(data_byte, last_byte);
			errors <= errors + fails;
			pending <= words_due.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	// A run is declared hung once this many cycles pass with no word moving on either side.
	// The longest honest quiet stretch is a long stall plus a config pause.
	localparam int HANG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        end_of_run;
	logic [31:0] crc_value;
	logic        part_end;

	int          errors;
	int          pending;
	int          idle_cycles = 0;
	int          hold = 0;
	// When calm is set, neither side inserts gaps, so the block runs at its full rate.
	logic        calm = 1'b0;

	always #5 clk = ~clk;

	yenc_line_encoder_crc32 i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.end_of_run (end_of_run),
		.crc_value  (crc_value),
		.part_end   (part_end)
	);

	yenc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.end_of_run (end_of_run),
		.crc_value  (crc_value),
		.part_end   (part_end),
		.errors     (errors),
		.pending    (pending)
	);

	// Most stalls are short; about one in five is long enough to fill the
	// block's internal queue and push back on the sender.
	function automatic int stall_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// The sender idles between words about half the time, again mostly briefly.
	function automatic int send_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Source bytes that land on a character needing an escape once the offset is added are
	// picked on purpose about one time in six, since plain random bytes rarely hit them.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 5) != 0)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
			0: return yle_pkg::NUL_CHAR - yle_pkg::ENC_OFFSET;
			1: return yle_pkg::TAB_CHAR - yle_pkg::ENC_OFFSET;
			2: return yle_pkg::LF_CHAR - yle_pkg::ENC_OFFSET;
			3: return yle_pkg::CR_CHAR - yle_pkg::ENC_OFFSET;
			4: return yle_pkg::ESC_CHAR - yle_pkg::ENC_OFFSET;
			default: return yle_pkg::DOT_CHAR - yle_pkg::ENC_OFFSET;
		endcase
	endfunction

	// The receiver pops freely and now and then stalls for a while. Only one assignment to
	// pop happens per edge, so a word is never dropped by a glitch in the same time step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold <= 0;
		end else if (hold > 0) begin
			pop <= 1'b0;
			hold <= hold - 1;
		end else begin
			pop <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				hold <= stall_len();
		end
	end

	// The watchdog only counts quiet cycles, so it scales with stalls rather than run length.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == HANG_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	// Offers one source byte and returns at the edge where the block takes it. When the next
	// word follows without a gap, push simply stays high.
	task automatic put_byte(input logic [7:0] d, input logic l);
		int g;
		g = send_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (full);
	endtask

	// Stops sending and waits until every predicted word has been popped. The first edge lets
	// the checker count the byte accepted just now before its pending count is trusted.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// The line length is changed only while the block is idle. The short pause only adds margin:
	// the emitter has already finished a run by the time its final word has left.
	task automatic set_line_length(input logic [7:0] len);
		drain();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends well-formed parts of random content: each part is a run of bytes closed by a
	// byte marked last. A part still open at the end of a phase simply carries over.
	task automatic run_phase(input logic [7:0] len, input int count, input int min_part,
			input int max_part, input logic quiet);
		int sent;
		int left;
		set_line_length(len);
		calm = quiet;
		sent = 0;
		left = $urandom_range(min_part, max_part);
		while (sent < count) begin
			left = left - 1;
			put_byte(pick_byte(), left == 0);
			if (left == 0)
				left = $urandom_range(min_part, max_part);
			sent = sent + 1;
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset line length: both extremes of the byte, then every source byte that needs an
		// escape, the last one closing the part. A last byte on an empty line follows.
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(yle_pkg::NUL_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(yle_pkg::TAB_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(yle_pkg::LF_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(yle_pkg::CR_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(yle_pkg::ESC_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(yle_pkg::DOT_CHAR - yle_pkg::ENC_OFFSET, 1'b1);
		put_byte(8'h78, 1'b1);

		// A zero line length puts CR LF after every encoded byte, escaped ones included.
		set_line_length(8'd0);
		put_byte(8'h07, 1'b0);
		put_byte(yle_pkg::NUL_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(8'hC8, 1'b1);

		// With a line length of one, an escape pair overshoots the limit but stays whole.
		set_line_length(8'd1);
		put_byte(yle_pkg::ESC_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(8'h64, 1'b0);
		put_byte(yle_pkg::DOT_CHAR - yle_pkg::ENC_OFFSET, 1'b1);

		// With three, escape pairs land both exactly on the limit and across it.
		set_line_length(8'd3);
		put_byte(8'h41, 1'b0);
		put_byte(yle_pkg::LF_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(8'h05, 1'b0);
		put_byte(8'h06, 1'b0);
		put_byte(yle_pkg::CR_CHAR - yle_pkg::ENC_OFFSET, 1'b0);
		put_byte(8'h01, 1'b1);

		// Random phases across the range of line lengths. The longest setting gets long parts
		// so that full lines and the count near its top are reached; some phases run calm.
		run_phase(8'd255, 240, 230, 320, 1'b0);
		run_phase(8'd0, 15, 1, 6, 1'b0);
		run_phase(8'd1, 15, 1, 10, 1'b1);
		run_phase(8'd2, 15, 1, 12, 1'b0);
		run_phase(8'($urandom_range(3, 20)), 15, 5, 30, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 15, 1, 40, 1'b1);
		run_phase(yle_pkg::LINE_LEN_RST, 15, 1, 40, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
